FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the model evaluation checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define DLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define DLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/dlsg2_pkg.sv
// ----------------------------------------------------------------------------
// dlsg2_pkg
// Types, constants and the 2^(-j/16) table for the g2 model evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package dlsg2_pkg;

  // register indexes on the config port
  typedef enum logic [2:0] {
    CFG_COMP_COUNT = 3'd0,
    CFG_BASELINE   = 3'd1,
    CFG_Q_SQUARE   = 3'd2,
    CFG_COMP1_WORD = 3'd3,
    CFG_COMP2_WORD = 3'd4,
    CFG_COMP3_WORD = 3'd5,
    CFG_COMP4_WORD = 3'd6
  } cfg_idx_e;

  localparam int unsigned MaxComponents = 4;
  localparam int unsigned CompRegs      = 4;
  localparam int unsigned Latency       = 15;

  // register reset values
  localparam logic [2:0]  CompCountRst = 3'd1;
  localparam logic [31:0] BaselineRst  = 32'd16777216;
  localparam logic [31:0] QSquareRst   = 32'd614989824;
  localparam logic [63:0] CompWordRst  = 64'd72057594038055936;

  // fixed-point constants
  localparam logic [30:0] OneQ30   = 31'h4000_0000;
  localparam logic [30:0] XCap     = 31'h4000_0000;
  localparam logic [30:0] Log2eQ30 = 31'd1549082005;
  localparam logic [31:0] Ln2Q32   = 32'd2977044472;
  localparam logic [31:0] Recip3   = 32'hAAAA_AAAB;

  typedef logic [15:0][30:0] pow2_tab_t;

  // integer square root, digit by digit
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    rem = v;
    b   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > rem) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (rem >= r + b) begin
          rem = rem - (r + b);
          r   = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // entry j holds 2^(-j/16) in Q1.30, built from chained square roots
  function automatic pow2_tab_t build_pow2_tab();
    pow2_tab_t   tab;
    logic [63:0] root [4];
    logic [63:0] v;
    root[0] = isqrt64(64'd1 << 59);
    for (int b = 1; b < 4; b++) root[b] = isqrt64(root[b-1] << 30);
    for (int j = 0; j < 16; j++) begin
      v = 64'd1 << 30;
      for (int b = 0; b < 4; b++) begin
        if (((j >> (3 - b)) & 1) != 0) v = (v * root[b]) >> 30;
      end
      tab[j] = v[30:0];
    end
    return tab;
  endfunction

  localparam pow2_tab_t Pow2Tab = build_pow2_tab();

endpackage

`default_nettype wire

FILE: sv/dls_g2_model_eval_unit.sv
// An accepted start travels down the valid bits, one per stage, to the done strobe.
// Throughput: one lag word per cycle; every component has its own lane of
// the fifteen-stage pipeline and the lanes are summed in one stage.
// busy_o stays low: there is no stall path and results cannot be held off.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none

module dls_g2_model_eval_unit #(
  parameter int unsigned MAX_COMPONENTS = dlsg2_pkg::MaxComponents
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] lag_time_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output logic        done_o,
  output logic [63:0] model_value_o,
  output logic        saturated_o
);
  import dlsg2_pkg::*;

  localparam int unsigned Lanes = (MAX_COMPONENTS < CompRegs) ? MAX_COMPONENTS : CompRegs;

  // configuration registers
  logic [2:0]  comp_count_q;
  logic [31:0] baseline_q;
  logic [31:0] q_square_q;
  logic [63:0] comp_word_q [CompRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_count_q <= CompCountRst;
      baseline_q   <= BaselineRst;
      q_square_q   <= QSquareRst;
      for (int i = 0; i < CompRegs; i++) comp_word_q[i] <= CompWordRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COMP_COUNT: comp_count_q   <= cfg_wdata_i[2:0];
        CFG_BASELINE:   baseline_q     <= cfg_wdata_i[31:0];
        CFG_Q_SQUARE:   q_square_q     <= cfg_wdata_i[31:0];
        CFG_COMP1_WORD: comp_word_q[0] <= cfg_wdata_i;
        CFG_COMP2_WORD: comp_word_q[1] <= cfg_wdata_i;
        CFG_COMP3_WORD: comp_word_q[2] <= cfg_wdata_i;
        CFG_COMP4_WORD: comp_word_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // valid bits, one per stage
  logic [Latency:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-1:1], start_i};
    end
  end

  assign busy_o = 1'b0;
  assign done_o = vld_q[Latency];

  // lag word into stage 1
  logic [31:0] t1_q;
  always_ff @(posedge clk_i) begin
    t1_q <= lag_time_i;
  end

  logic [31:0] term_w [Lanes];

  // one decay lane per component
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [63:0] qd1_q;
    logic [63:0] ph2_q, pl2_q;
    logic [30:0] x3_q;
    logic [30:0] y4_q;
    logic [25:0] u5_q, u6_q, u7_q, u8_q;
    logic [3:0]  j5_q, j6_q, j7_q, j8_q, j9_q;
    logic [4:0]  k5_q, k6_q, k7_q, k8_q, k9_q, k10_q;
    logic        kz5_q, kz6_q, kz7_q, kz8_q, kz9_q, kz10_q;
    logic [56:0] p6_q, p8_q, p9_q;
    logic [58:0] m7_q;
    logic [61:0] p10_q;
    logic [30:0] e11_q;
    logic [31:0] term12_q;

    logic [36:0] x_sum;
    logic [30:0] x_d;
    logic [61:0] y_full;
    logic [51:0] u_full;
    logic [6:0]  k_int;
    logic [30:0] a1, a2, a3, a4;
    logic [62:0] t_prod;

    // exponent x clipped at 64.0
    assign x_sum = {7'd0, ph2_q[25:0], 4'd0} + {1'b0, pl2_q[63:28]};
    assign x_d   = (ph2_q >= 64'h400_0000) ? XCap :
                   ((x_sum > {6'd0, XCap}) ? XCap : x_sum[30:0]);
    assign y_full = 62'(x3_q) * 62'(Log2eQ30);
    assign u_full = 52'(y4_q[19:0]) * 52'(Ln2Q32);
    assign k_int  = y4_q[30:24];

    // polynomial steps for the fraction of 1/16
    assign a1 = OneQ30 - 31'(u5_q >> 2);
    assign a2 = OneQ30 - 31'(m7_q[58:33]);
    assign a3 = OneQ30 - 31'(p8_q[56:31]);
    assign a4 = OneQ30 - 31'(p9_q[56:30]);
    assign t_prod = 63'(comp_word_q[l][63:32]) * 63'(e11_q);

    always_ff @(posedge clk_i) begin
      qd1_q    <= 64'(q_square_q) * 64'(comp_word_q[l][31:0]);
      ph2_q    <= 64'(qd1_q[63:32]) * 64'(t1_q);
      pl2_q    <= 64'(qd1_q[31:0]) * 64'(t1_q);
      x3_q     <= x_d;
      y4_q     <= y_full[60:30];
      u5_q     <= u_full[51:26];
      j5_q     <= y4_q[23:20];
      k5_q     <= k_int[4:0];
      kz5_q    <= (k_int >= 7'd31);
      p6_q     <= 57'(u5_q) * 57'(a1);
      u6_q     <= u5_q;
      j6_q     <= j5_q;
      k6_q     <= k5_q;
      kz6_q    <= kz5_q;
      // divide by three through the reciprocal
      m7_q     <= 59'(p6_q[56:30]) * 59'(Recip3);
      u7_q     <= u6_q;
      j7_q     <= j6_q;
      k7_q     <= k6_q;
      kz7_q    <= kz6_q;
      p8_q     <= 57'(u7_q) * 57'(a2);
      u8_q     <= u7_q;
      j8_q     <= j7_q;
      k8_q     <= k7_q;
      kz8_q    <= kz7_q;
      p9_q     <= 57'(u8_q) * 57'(a3);
      j9_q     <= j8_q;
      k9_q     <= k8_q;
      kz9_q    <= kz8_q;
      p10_q    <= 62'(Pow2Tab[j9_q]) * 62'(a4);
      k10_q    <= k9_q;
      kz10_q   <= kz9_q;
      // integer part of the exponent as a right shift
      e11_q    <= kz10_q ? '0 : (p10_q[60:30] >> k10_q);
      term12_q <= t_prod[61:30];
    end

    assign term_w[l] = term12_q;
  end

  // sum of the active lanes; component 1 always counts
  logic [33:0] g1_d, g1_13_q;
  always_comb begin
    g1_d = '0;
    for (int l = 0; l < Lanes; l++) begin
      if (l == 0 || 3'(l) < comp_count_q) g1_d = g1_d + 34'(term_w[l]);
    end
  end

  // partial products of the square
  logic [19:0] hh14_q;
  logic [33:0] hl14_q;
  logic [47:0] ll14_q;
  logic [63:0] sq_d, res_d;
  logic [63:0] model_value_q;

  assign sq_d  = {20'd0, hh14_q, 24'd0} + {29'd0, hl14_q, 1'b0} + {40'd0, ll14_q[47:24]};
  assign res_d = sq_d + {{32{baseline_q[31]}}, baseline_q};

  always_ff @(posedge clk_i) begin
    g1_13_q <= g1_d;
    hh14_q  <= 20'(g1_13_q[33:24]) * 20'(g1_13_q[33:24]);
    hl14_q  <= 34'(g1_13_q[33:24]) * 34'(g1_13_q[23:0]);
    ll14_q  <= 48'(g1_13_q[23:0]) * 48'(g1_13_q[23:0]);
    if (vld_q[Latency-1]) model_value_q <= res_d;
  end

  // the square stays far below the clip limit
  assign model_value_o = model_value_q;
  assign saturated_o   = 1'b0;

endmodule

`default_nettype wire

FILE: sv/dlsg2_checker.sv
// ----------------------------------------------------------------------------
// dlsg2_checker
// Port-level timing checks for the g2 model evaluator
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dlsg2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic        saturated_o
);
  import dlsg2_pkg::*;

  logic acc;
  assign acc = start_i && !busy_o;

  // every accepted word comes out after the fixed latency
  `DLS_ASSERT_IMP(a_word_out, clk_i, rst_ni, acc, ##Latency done_o)

  // no result without a word accepted a latency earlier
  `DLS_ASSERT_IMP(a_no_ghost, clk_i, rst_ni, done_o, $past(acc, Latency))

  // a result never reports clipping
  `DLS_ASSERT_IMP(a_no_sat, clk_i, rst_ni, done_o, !saturated_o)

  // the unit never pushes back
  `DLS_ASSERT_NEXT(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)

endmodule

bind dls_g2_model_eval_unit dlsg2_checker u_dlsg2_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .done_o      (done_o),
  .saturated_o (saturated_o)
);

`default_nettype wire

FILE: tb/dls_g2_model_eval_unit_tb.sv
// ----------------------------------------------------------------------------
// dls_g2_model_eval_unit_tb
// Drives lag words into the g2 model evaluator, predicts each model value
// from the register settings in fixed point and checks the done words.
// ----------------------------------------------------------------------------
`default_nettype none

module dls_g2_model_eval_unit_tb;
  import dlsg2_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] lag_time_i = '0;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic        done_o;
  logic [63:0] model_value_o;
  logic        saturated_o;

  typedef struct packed {
    logic [63:0] value;
    logic        sat;
  } model_word_t;

  // shadow registers for prediction
  logic [2:0]  shd_count;
  logic [31:0] shd_baseline;
  logic [31:0] shd_qsq;
  logic [63:0] shd_comp [4];
  logic [63:0] tab2 [16];

  logic [31:0] lag_queue [$];
  model_word_t model_queue [$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned gap_left = 0;
  bit          hold_off;

  dls_g2_model_eval_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .lag_time_i   (lag_time_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .done_o       (done_o),
    .model_value_o(model_value_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // integer square root for the 2^(-j/16) table
  function automatic logic [63:0] root_of(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void make_table();
    logic [63:0] rt [4];
    logic [63:0] v;
    rt[0] = root_of(64'd1 << 59);
    for (int b = 1; b < 4; b++) rt[b] = root_of(rt[b-1] << 30);
    for (int j = 0; j < 16; j++) begin
      v = 64'd1 << 30;
      for (int b = 0; b < 4; b++)
        if (((j >> (3 - b)) & 1) != 0) v = (v * rt[b]) >> 30;
      tab2[j] = v;
    end
  endfunction

  // exp(-x), x in Q.24, result Q1.30
  function automatic logic [63:0] exp_decay(logic [63:0] x);
    logic [63:0] y, k, f, g, u, a, e;
    y = (x * 64'd1549082005) >> 30;
    k = y >> 24;
    f = y & 64'hFFFFFF;
    g = f & 64'hFFFFF;
    u = (g * 64'd2977044472) >> 26;
    if (k >= 31) return 64'd0;
    a = (64'd1 << 30) - (u >> 2);
    a = (64'd1 << 30) - ((u * a) >> 30) / 3;
    a = (64'd1 << 30) - (((u * a) >> 30) >> 1);
    a = (64'd1 << 30) - ((u * a) >> 30);
    e = (tab2[(f >> 20) & 15] * a) >> 30;
    return e >> k;
  endfunction

  function automatic logic [63:0] comp_term(logic [63:0] w, logic [63:0] t);
    logic [63:0] fr, dc, qd, ph, x;
    fr = w >> 32;
    dc = w & 64'hFFFFFFFF;
    qd = {32'd0, shd_qsq} * dc;
    ph = (qd >> 32) * t;
    if (ph >= ((64'd64 << 24) >> 4)) begin
      x = 64'd64 << 24;
    end else begin
      x = (ph << 4) + (((qd & 64'hFFFFFFFF) * t) >> 28);
      if (x > (64'd64 << 24)) x = 64'd64 << 24;
    end
    return (fr * exp_decay(x)) >> 30;
  endfunction

  function automatic model_word_t predict_model(logic [31:0] lag);
    model_word_t r;
    int unsigned n;
    logic [63:0] g1, hi, lo, sq, lim;
    logic [63:0] base;
    n = shd_count;
    if (n < 1) n = 1;
    if (n > MaxComponents) n = MaxComponents;
    if (n > CompRegs) n = CompRegs;
    g1 = '0;
    for (int i = 0; i < n; i++) g1 += comp_term(shd_comp[i], {32'd0, lag});
    hi = g1 >> 24;
    lo = g1 & 64'hFFFFFF;
    sq = ((hi * hi) << 24) + 2 * hi * lo + ((lo * lo) >> 24);
    base = {{32{shd_baseline[31]}}, shd_baseline};
    lim = 64'h7FFF_FFFF_FFFF_FFFF - (64'd1 << 31);
    if (sq > lim) begin
      r.value = 64'h7FFF_FFFF_FFFF_FFFF;
      r.sat   = 1'b1;
    end else begin
      r.value = sq + base;
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_lag();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(0, 255);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return $urandom_range(0, 32'h0100_0000) >> $urandom_range(0, 12);
    endcase
  endfunction

  // register write at the falling edge, shadow updated alongside
  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_COMP_COUNT: shd_count    = data[2:0];
      CFG_BASELINE:   shd_baseline = data[31:0];
      CFG_Q_SQUARE:   shd_qsq      = data[31:0];
      CFG_COMP1_WORD: shd_comp[0]  = data;
      CFG_COMP2_WORD: shd_comp[1]  = data;
      CFG_COMP3_WORD: shd_comp[2]  = data;
      CFG_COMP4_WORD: shd_comp[3]  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (lag_queue.size() != 0 || model_queue.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_comp();
    logic [31:0] fr, dc;
    case ($urandom_range(0, 3))
      0:       fr = $urandom;
      default: fr = $urandom_range(0, 32'h0200_0000);
    endcase
    case ($urandom_range(0, 3))
      0:       dc = $urandom;
      1:       dc = $urandom_range(0, 255);
      default: dc = $urandom_range(0, 32'h0004_0000);
    endcase
    return {fr, dc};
  endfunction

  // lag word driver: one word per cycle unless a gap is drawn or the driver is held off
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      start_i <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start_i  <= 1'b0;
    end else if (lag_queue.size() != 0) begin
      start_i    <= 1'b1;
      lag_time_i <= lag_queue[0];
      if ($urandom_range(0, 3) == 0)
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                : $urandom_range(1, 3);
    end else begin
      start_i <= 1'b0;
    end
  end

  // accept on start and predict; check done words
  always @(posedge clk_i) begin
    model_word_t exp_w;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (start_i && !busy_o) begin
        model_queue.push_back(predict_model(lag_time_i));
        void'(lag_queue.pop_front());
      end
      if (done_o) begin
        if (model_queue.size() == 0) begin
          $display("%0t: unexpected model word value=%h sat=%b", $realtime,
                   model_value_o, saturated_o);
          errors <= errors + 1;
        end else begin
          exp_w = model_queue.pop_front();
          checked <= checked + 1;
          if (model_value_o !== exp_w.value || saturated_o !== exp_w.sat) begin
            $display("%0t: model mismatch expected value=%h sat=%b actual value=%h sat=%b",
                     $realtime, exp_w.value, exp_w.sat, model_value_o, saturated_o);
            errors <= errors + 1;
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] dir_lags [] = '{32'd0, 32'd1, 32'h0000_0100, 32'h0001_0000, 32'h0010_0000,
                                 32'h0100_0000, 32'h0800_0000, 32'h8000_0000,
                                 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_COMP_COUNT;
    cfg_wdata_i = '0;
    hold_off = 1'b0;
    make_table();
    shd_count = CompCountRst;
    shd_baseline = BaselineRst;
    shd_qsq = QSquareRst;
    for (int i = 0; i < 4; i++) shd_comp[i] = CompWordRst;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, then corners of count, baseline and the words
    foreach (dir_lags[i]) lag_queue.push_back(dir_lags[i]);
    wait_idle();
    write_reg(CFG_COMP_COUNT, 64'd0);
    write_reg(CFG_BASELINE, 64'h8000_0000);
    write_reg(CFG_COMP1_WORD, 64'hFFFF_FFFF_0000_0000);
    foreach (dir_lags[i]) if (i < 5) lag_queue.push_back(dir_lags[i]);
    wait_idle();
    write_reg(CFG_COMP_COUNT, 64'd7);
    write_reg(CFG_BASELINE, 64'h7FFF_FFFF);
    write_reg(CFG_Q_SQUARE, 64'hFFFF_FFFF);
    write_reg(CFG_COMP2_WORD, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_COMP3_WORD, 64'hFFFF_FFFF_0000_0001);
    write_reg(CFG_COMP4_WORD, 64'hFFFF_FFFF_0000_0000);
    foreach (dir_lags[i]) if (i < 6) lag_queue.push_back(dir_lags[i]);
    wait_idle();
    write_reg(CFG_Q_SQUARE, 64'd0);
    lag_queue.push_back(32'hFFFF_FFFF);
    lag_queue.push_back(32'h0100_0000);
    wait_idle();

    // random phases, each with fresh settings
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_COMP_COUNT, 64'($urandom_range(0, 7)));
      write_reg(CFG_BASELINE, (ph == 3) ? 64'h8000_0000 : {32'd0, $urandom});
      write_reg(CFG_Q_SQUARE, (ph == 5) ? 64'hFFFF_FFFF :
                              {32'd0, $urandom_range(0, 32'h4000_0000)});
      write_reg(CFG_COMP1_WORD, rand_comp());
      write_reg(CFG_COMP2_WORD, rand_comp());
      write_reg(CFG_COMP3_WORD, rand_comp());
      write_reg(CFG_COMP4_WORD, (ph == 7) ? 64'hFFFF_FFFF_FFFF_FFFF : rand_comp());
      for (int n = 0; n < 78; n++) lag_queue.push_back(rand_lag());
      // one phase holds off mid-way until the pipeline has drained
      if (ph == 6) begin
        while (lag_queue.size() > 40) @(posedge clk_i);
        hold_off = 1'b1;
        while (model_queue.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
        hold_off = 1'b0;
      end
      wait_idle();
    end

    $display("covered %0d model words over 16 register settings incl. count and word extremes",
             checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+sv
sv/dlsg2_pkg.sv
sv/dls_g2_model_eval_unit.sv
sv/dlsg2_checker.sv
tb/dls_g2_model_eval_unit_tb.sv
